>>> hdl/apsp_pkg.sv
// types and constants shared by the all-pairs shortest path unit
`default_nettype none

package apsp_pkg;

   localparam int NODE_W = 6;
   localparam int COST_W = 16;
   localparam int DIST_W = 22;
   localparam int CNT_W  = 7;

   localparam logic [DIST_W-1:0] UNREACHABLE      = 22'h3F_FFFF;
   localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_EDGE  = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [NODE_W-1:0]   row_node;
      logic [NODE_W-1:0]   col_node;
      logic [COST_W-1:0]   cost;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0]   distance;
      logic                reachable;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_EDGE,
      ST_ROWLD,
      ST_COLRD,
      ST_RELAX,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

>>> hdl/apsp_ram.sv
// generic simple dual-port ram, one write port and one registered read port
`default_nettype none

module apsp_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/all_pairs_shortest_path_unit.sv
// top level of the all-pairs shortest path (floyd-warshall) unit
`default_nettype none

// Distances live in one dual-port RAM of (2**ceil(log2 MAX_NODES))**2 entries of 22 bits
// (one read and one write per cycle), with row k of the current pass cached in a second
// RAM of one row. With n = min(node_count, MAX_NODES): a clear beat writes one entry a
// cycle over n*n entries; an edge beat writes two table entries, (row,col) then (col,row);
// a read beat's result passes the registered RAM read into the output queue, where up to
// two results queue; a run beat holds off input until it drains: per pass k, it copies row
// k, then per row it fetches d(i,k) and streams d(i,j) through a read-add-compare-write
// pipeline. Entries never written read back undefined.
module all_pairs_shortest_path_unit
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_data
);

   localparam int NW    = $clog2(MAX_NODES);
   localparam int CW    = $clog2(MAX_NODES + 1);
   localparam int AW    = 2 * NW;
   localparam int DEPTH = 1 << AW;
   localparam int ROWS  = 1 << NW;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  node_count_ff;
   logic [NW-1:0]     k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [NW-1:0]     er_ff, ec_ff;
   logic [COST_W-1:0] cost_ff;
   logic              ld_vld_ff;
   logic [NW-1:0]     ld_idx_ff;
   logic              dik_ld_ff;
   logic [DIST_W-1:0] dik_ff;
   logic              rx_vld_ff;
   logic [AW-1:0]     rx_addr_ff;
   logic              rd_vld_ff, rd_oor_ff;
   logic [1:0]        cnt_ff, cnt_in;
   rsp_type           q0_ff, q1_ff;

   logic [CW-1:0]     act;
   logic              act_zero;
   logic [NW-1:0]     last_idx;
   logic              i_last, j_last, k_last;
   logic              req_fire, req_in_range, fifo_room;
   logic [NW-1:0]     req_r, req_c;

   logic              main_wr_en;
   logic [AW-1:0]     main_wr_addr, main_rd_addr;
   logic [DIST_W-1:0] main_wr_data, main_rd_data;
   logic [DIST_W-1:0] row_rd_data;

   logic [DIST_W:0]   relax_sum;
   logic [DIST_W-1:0] relax_dist;
   logic              relax_better;

   logic              push, pop;
   rsp_type           push_data;
   logic [DIST_W-1:0] rd_dist;

   assign act      = (int'(node_count_ff) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_ff);
   assign act_zero = (act == '0);
   assign last_idx = NW'(act - CW'(1));
   assign i_last   = (i_ff == last_idx);
   assign j_last   = (j_ff == last_idx);
   assign k_last   = (k_ff == last_idx);

   assign req_r        = NW'(req_data.row_node);
   assign req_c        = NW'(req_data.col_node);
   assign req_in_range = (int'(req_data.row_node) < MAX_NODES)
                      && (int'(req_data.col_node) < MAX_NODES);
   assign fifo_room    = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rd_vld_ff);
   assign req_ready    = (state_ff == ST_IDLE) && fifo_room;
   assign req_fire     = req_valid && req_ready;
   assign csr_ready    = 1'b1;

   // next state and loop counters
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.op)
                  OP_CLEAR: begin
                     if (!act_zero) begin
                        state_in = ST_CLEAR;
                        i_in     = '0;
                        j_in     = '0;
                     end
                  end
                  OP_EDGE: begin
                     if (req_in_range) begin
                        state_in = ST_EDGE;
                     end
                  end
                  OP_RUN: begin
                     if (!act_zero) begin
                        state_in = ST_ROWLD;
                        k_in     = '0;
                        i_in     = '0;
                        j_in     = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_EDGE: begin
            state_in = ST_IDLE;
         end
         ST_ROWLD: begin
            if (j_last) begin
               j_in     = '0;
               i_in     = '0;
               state_in = ST_COLRD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_COLRD: begin
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  i_in = '0;
                  if (k_last) begin
                     state_in = ST_DRAIN;
                  end else begin
                     k_in     = k_ff + 1'b1;
                     state_in = ST_ROWLD;
                  end
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_COLRD;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // relaxation datapath
   assign relax_sum    = {1'b0, dik_ff} + {1'b0, row_rd_data};
   assign relax_dist   = (relax_sum > {1'b0, UNREACHABLE}) ? UNREACHABLE : relax_sum[DIST_W-1:0];
   assign relax_better = relax_dist < main_rd_data;

   // memory port control
   always_comb begin
      main_wr_en   = 1'b0;
      main_wr_addr = rx_addr_ff;
      main_wr_data = relax_dist;
      main_rd_addr = {i_ff, j_ff};
      if (rx_vld_ff) begin
         main_wr_en = relax_better;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_data.op == OP_EDGE) && req_in_range) begin
                  main_wr_en   = 1'b1;
                  main_wr_addr = {req_r, req_c};
                  main_wr_data = DIST_W'(req_data.cost);
               end
            end
            ST_EDGE: begin
               main_wr_en   = 1'b1;
               main_wr_addr = {ec_ff, er_ff};
               main_wr_data = DIST_W'(cost_ff);
            end
            ST_CLEAR: begin
               main_wr_en   = 1'b1;
               main_wr_addr = {i_ff, j_ff};
               main_wr_data = (i_ff == j_ff) ? '0 : UNREACHABLE;
            end
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE:  main_rd_addr = {req_r, req_c};
         ST_ROWLD: main_rd_addr = {k_ff, j_ff};
         ST_COLRD: main_rd_addr = {i_ff, k_ff};
         default:  main_rd_addr = {i_ff, j_ff};
      endcase
   end

   apsp_ram #(
      .WIDTH (DIST_W),
      .DEPTH (DEPTH)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (main_wr_en),
      .wr_addr (main_wr_addr),
      .wr_data (main_wr_data),
      .rd_addr (main_rd_addr),
      .rd_data (main_rd_data)
   );

   apsp_ram #(
      .WIDTH (DIST_W),
      .DEPTH (ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ld_vld_ff),
      .wr_addr (ld_idx_ff),
      .wr_data (main_rd_data),
      .rd_addr (j_ff),
      .rd_data (row_rd_data)
   );

   // result queue
   assign rd_dist            = rd_oor_ff ? UNREACHABLE : main_rd_data;
   assign push_data.distance = rd_dist;
   assign push_data.reachable = (rd_dist != UNREACHABLE);
   assign push               = rd_vld_ff;
   assign pop                = rsp_valid && rsp_ready;
   assign rsp_valid          = (cnt_ff != 2'd0);
   assign rsp_data           = q0_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         k_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         ld_vld_ff     <= 1'b0;
         dik_ld_ff     <= 1'b0;
         rx_vld_ff     <= 1'b0;
         rd_vld_ff     <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         ld_vld_ff <= (state_ff == ST_ROWLD);
         dik_ld_ff <= (state_ff == ST_COLRD);
         rx_vld_ff <= (state_ff == ST_RELAX);
         rd_vld_ff <= req_fire && (req_data.op == OP_READ);
         cnt_ff    <= cnt_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ld_idx_ff  <= j_ff;
      rx_addr_ff <= {i_ff, j_ff};
      rd_oor_ff  <= !req_in_range;
      if (dik_ld_ff) begin
         dik_ff <= main_rd_data;
      end
      if (req_fire) begin
         er_ff   <= req_r;
         ec_ff   <= req_c;
         cost_ff <= req_data.cost;
      end
      if (pop && (cnt_ff == 2'd2)) begin
         q0_ff <= q1_ff;
         if (push) begin
            q1_ff <= push_data;
         end
      end else if (pop) begin
         if (push) begin
            q0_ff <= push_data;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            q0_ff <= push_data;
         end else begin
            q1_ff <= push_data;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/apsp_checker.sv
// port-level checks for the all-pairs shortest path unit and their bind
`default_nettype none

module apsp_checker
   import apsp_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire req_type          req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rsp_type          rsp_data,
   input wire logic             csr_valid,
   input wire logic             csr_ready,
   input wire logic [CNT_W-1:0] csr_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat dropped or changed while stalled");

   // reachable flag matches the distance
   a_reach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.reachable == (rsp_data.distance != UNREACHABLE)))
      else $error("reachable flag disagrees with distance");

   // a result appears only after a read beat
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_data.op == OP_READ), 2))
      else $error("result without a read beat");

   // config writes are never stalled
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write stalled");

endmodule

bind all_pairs_shortest_path_unit apsp_checker u_apsp_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// testbench for the all-pairs shortest path unit: directed and random graphs
`timescale 1ns / 1ps

module tb;
   import apsp_pkg::*;

   localparam int NODES       = 64;
   localparam int ITEM_TARGET = 550;
   localparam int QUIET_FROM  = ITEM_TARGET - 60;
   localparam int STALL_LIMIT = 1000000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data  = '0;

   logic [DIST_W-1:0] dist_mirror [NODES][NODES];
   logic [CNT_W-1:0]  node_count_q = NODE_COUNT_RESET;
   rsp_type           expected_dist [$];
   int                hold_cycles    = 0;
   int                items_sent     = 0;
   int                mismatch_count = 0;
   int                stall_left     = 0;
   int                idle_cycles    = 0;
   bit                calm_phase     = 1'b0;

   wire idle_off = calm_phase || (items_sent >= QUIET_FROM);

   all_pairs_shortest_path_unit #(
      .MAX_NODES(NODES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int active_nodes();
      return (node_count_q > NODES) ? NODES : int'(node_count_q);
   endfunction

   function automatic void relax_mirror(input int n);
      logic [DIST_W:0] sum;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               sum = {1'b0, dist_mirror[i][k]} + {1'b0, dist_mirror[k][j]};
               if (sum > {1'b0, UNREACHABLE}) sum = {1'b0, UNREACHABLE};
               if (sum < {1'b0, dist_mirror[i][j]}) dist_mirror[i][j] = sum[DIST_W-1:0];
            end
         end
      end
   endfunction

   function automatic void update_mirror(input req_type item);
      int n;
      rsp_type want;
      n = active_nodes();
      case (item.op)
         OP_CLEAR: begin
            for (int i = 0; i < n; i++)
               for (int j = 0; j < n; j++)
                  dist_mirror[i][j] = (i == j) ? '0 : UNREACHABLE;
            hold_cycles = n * n + 4;
         end
         OP_EDGE: begin
            dist_mirror[item.row_node][item.col_node] = DIST_W'(item.cost);
            dist_mirror[item.col_node][item.row_node] = DIST_W'(item.cost);
            hold_cycles = 4;
         end
         OP_RUN: begin
            relax_mirror(n);
            hold_cycles = n * (n * n + 2 * n) + 4;
         end
         default: begin
            want.distance  = dist_mirror[item.row_node][item.col_node];
            want.reachable = (want.distance != UNREACHABLE);
            expected_dist.insert(expected_dist.size(), want);
            hold_cycles = 4;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: %s got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_op(input op_type op, input logic [NODE_W-1:0] row,
                          input logic [NODE_W-1:0] col, input logic [COST_W-1:0] cost);
      req_type item;
      item.op       = op;
      item.row_node = row;
      item.col_node = col;
      item.cost     = cost;
      if (!idle_off && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      update_mirror(item);
      items_sent++;
   endtask

   task automatic wait_for_reads();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_dist.size() != 0);
   endtask

   task automatic set_node_count(input logic [CNT_W-1:0] value);
      wait_for_reads();
      repeat (hold_cycles) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      node_count_q = value;
      hold_cycles  = 0;
   endtask

   function automatic logic [NODE_W-1:0] pick_node(input int n);
      if (n > 0 && $urandom_range(0, 9) != 0) return NODE_W'($urandom_range(0, n - 1));
      return NODE_W'($urandom_range(0, NODES - 1));
   endfunction

   function automatic logic [COST_W-1:0] pick_cost();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return COST_W'($urandom_range(1, 100));
         default: return COST_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // whole table is cleared at the reset count, so every later read hits a written entry
   task automatic test_clear_at_reset_count();
      send_op(OP_CLEAR, 6'd0, 6'd0, 16'd0);
      send_op(OP_READ, 6'd63, 6'd62, 16'hFFFF);
      send_op(OP_READ, 6'd63, 6'd63, 16'd0);
      send_op(OP_READ, 6'd0, 6'd63, 16'd0);
   endtask

   task automatic test_edge_writes();
      send_op(OP_EDGE, 6'd5, 6'd5, 16'd7);
      send_op(OP_EDGE, 6'd1, 6'd2, 16'd0);
      send_op(OP_EDGE, 6'd2, 6'd1, 16'd10);
      send_op(OP_EDGE, 6'd0, 6'd63, 16'hFFFF);
      send_op(OP_EDGE, 6'd21, 6'd42, 16'h5555);
      send_op(OP_EDGE, 6'd42, 6'd63, 16'hAAAA);
      send_op(OP_READ, 6'd5, 6'd5, 16'd0);
      send_op(OP_READ, 6'd1, 6'd2, 16'd0);
      send_op(OP_READ, 6'd63, 6'd0, 16'd0);
      send_op(OP_READ, 6'd42, 6'd21, 16'd0);
   endtask

   // count above the table size saturates to a full 64-node relaxation
   task automatic test_full_table_relax();
      set_node_count(7'd100);
      send_op(OP_EDGE, 6'd63, 6'd62, 16'd1);
      send_op(OP_RUN, 6'd63, 6'd21, 16'hFFFF);
      send_op(OP_READ, 6'd0, 6'd62, 16'd0);
      send_op(OP_READ, 6'd21, 6'd0, 16'd0);
      send_op(OP_READ, 6'd30, 6'd31, 16'd0);
   endtask

   task automatic test_count_extremes();
      set_node_count(7'd0);
      send_op(OP_CLEAR, 6'd0, 6'd0, 16'd0);
      send_op(OP_RUN, 6'd0, 6'd0, 16'd0);
      send_op(OP_READ, 6'd2, 6'd1, 16'd0);
      set_node_count(7'd2);
      send_op(OP_CLEAR, 6'd0, 6'd0, 16'd0);
      send_op(OP_EDGE, 6'd0, 6'd1, 16'd4);
      send_op(OP_EDGE, 6'd1, 6'd40, 16'd1);
      send_op(OP_EDGE, 6'd40, 6'd0, 16'd1);
      send_op(OP_RUN, 6'd0, 6'd0, 16'd0);
      send_op(OP_READ, 6'd0, 6'd1, 16'd0);
      send_op(OP_READ, 6'd0, 6'd40, 16'd0);
   endtask

   task automatic test_random_graphs();
      int n;
      int pick;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) n = $urandom_range(1, 8);
         else if (pick < 19) n = $urandom_range(9, 16);
         else n = $urandom_range(17, 24);
         calm_phase = 1'b0;
         set_node_count(CNT_W'(n));
         calm_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 6) == 0) begin
            // noise: any op, any fields
            repeat ($urandom_range(5, 15))
               send_op(op_type'($urandom_range(0, 3)), pick_node(n), pick_node(n), pick_cost());
         end else begin
            send_op(OP_CLEAR, pick_node(0), pick_node(0), pick_cost());
            repeat ($urandom_range(0, 2 * n + 1))
               send_op(OP_EDGE, pick_node(n), pick_node(n), pick_cost());
            if ($urandom_range(0, 4) == 0) wait_for_reads();
            if ($urandom_range(0, 5) != 0)
               send_op(OP_RUN, pick_node(0), pick_node(0), pick_cost());
            repeat ($urandom_range(n, 2 * n + 2))
               send_op(OP_READ, pick_node(n), pick_node(n), pick_cost());
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, n + 1))
                  send_op(OP_EDGE, pick_node(n), pick_node(n), pick_cost());
               send_op(OP_RUN, pick_node(0), pick_node(0), pick_cost());
               repeat ($urandom_range(1, n + 1))
                  send_op(OP_READ, pick_node(n), pick_node(n), pick_cost());
            end
         end
      end
      calm_phase = 1'b0;
   endtask

   always @(posedge clock) begin
      if (idle_off) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // distance beat check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dist.size() == 0) begin
            report_mismatch("unexpected distance beat", rsp_data.distance, 0);
         end else begin
            want = expected_dist.pop_front();
            if (rsp_data.distance !== want.distance)
               report_mismatch("distance", rsp_data.distance, want.distance);
            if (rsp_data.reachable !== want.reachable)
               report_mismatch("reachable", rsp_data.reachable, want.reachable);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("all_pairs_shortest_path_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_clear_at_reset_count();
      test_edge_writes();
      test_full_table_relax();
      test_count_extremes();
      test_random_graphs();
      wait_for_reads();
      repeat (hold_cycles + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("all_pairs_shortest_path_unit: match");
      end else begin
         $display("all_pairs_shortest_path_unit: mismatch");
      end
      $finish;
   end

endmodule
